// ===== hdl/isu_pkg.sv =====
`default_nettype none

package isu_pkg;

  // capacity of the sorting chain
  localparam int unsigned MAX_ITEMS = 16;
  localparam int unsigned DATA_W    = 32;
  // fill count must hold MAX_ITEMS itself
  localparam int unsigned CNT_W     = $clog2(MAX_ITEMS + 1);

  // per-cycle commands broadcast to every cell of the chain
  typedef struct packed {
    logic ins;    // place the broadcast word into the chain
    logic shift;  // move every word one cell toward the head
  } isu_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/isu_cell.sv =====
`default_nettype none

module isu_cell (
  input  wire                                clk_i,
  input  wire isu_pkg::isu_ctl_t             ctl_i,
  input  wire logic signed [isu_pkg::DATA_W-1:0] new_value_i,
  input  wire logic signed [isu_pkg::DATA_W-1:0] prev_value_i,
  input  wire logic signed [isu_pkg::DATA_W-1:0] next_value_i,
  input  wire                                prev_gt_i,
  input  wire                                prev_occ_i,
  input  wire                                occ_i,
  output logic                               gt_o,
  output logic signed [isu_pkg::DATA_W-1:0]  value_o
);
  import isu_pkg::*;

  logic signed [DATA_W-1:0] value_q, value_d;
  logic                     take_new;

  // strictly greater keeps equal values in arrival order
  assign gt_o     = occ_i && (value_q > new_value_i);
  // first slot whose word is greater, or first empty slot
  assign take_new = !prev_gt_i && prev_occ_i && (gt_o || !occ_i);

  always_comb begin
    value_d = value_q;
    if (ctl_i.ins) begin
      if (prev_gt_i) begin
        value_d = prev_value_i;
      end else if (take_new) begin
        value_d = new_value_i;
      end
    end else if (ctl_i.shift) begin
      value_d = next_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

// ===== hdl/insertion_sorter_unit.sv =====
`default_nettype none

// stable streaming insertion sorter. signed 32-bit words enter one per cycle
// while in_stall_o is low and are dropped into place in a chain of MAX_ITEMS
// cells: every cell compares its word with the incoming one at once, and all
// greater words move one cell down in the same cycle. equal values keep
// arrival order. the word flagged last is inserted as well, then the chain
// drains through its head cell, one sorted word per cycle while the output is
// not stalled; the input is stalled while a run drains. the final output word
// carries last_out_o. words arriving with the chain full are dropped and
// overflow_o is raised on every output word of that run. no clearing pass
// after reset: the fill count alone says which cells hold data.

module insertion_sorter_unit (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // input channel
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [isu_pkg::DATA_W-1:0] value_i,
  input  wire                                last_i,
  // output channel
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output logic signed [isu_pkg::DATA_W-1:0]  sorted_value_o,
  output logic                               last_out_o,
  output logic                               overflow_o
);
  import isu_pkg::*;

  // run control
  logic             drain_q, drain_d;
  logic             dropped_q, dropped_d;
  logic [CNT_W-1:0] fill_q, fill_d;

  logic             in_acc, out_acc, full, end_run;
  isu_ctl_t         ctl;

  // chain wiring
  logic signed [DATA_W-1:0] cell_value [MAX_ITEMS];
  logic                     cell_gt    [MAX_ITEMS];
  logic                     cell_occ   [MAX_ITEMS];

  // handshakes: the input waits while a run drains
  assign in_stall_o  = drain_q;
  assign in_acc      = in_valid_i && !drain_q;
  assign out_valid_o = drain_q;
  assign out_acc     = drain_q && !out_stall_i;

  assign full    = (fill_q == CNT_W'(MAX_ITEMS));
  assign end_run = out_acc && (fill_q == CNT_W'(1));

  assign ctl.ins   = in_acc && !full;
  assign ctl.shift = out_acc;

  // fill count, drain flag and drop mark
  always_comb begin
    fill_d    = fill_q;
    drain_d   = drain_q;
    dropped_d = dropped_q;
    if (ctl.ins) begin
      fill_d = fill_q + CNT_W'(1);
    end
    if (in_acc && full) begin
      dropped_d = 1'b1;
    end
    if (in_acc && last_i) begin
      drain_d = 1'b1;
    end
    if (out_acc) begin
      fill_d = fill_q - CNT_W'(1);
    end
    if (end_run) begin
      drain_d   = 1'b0;
      dropped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      drain_q   <= 1'b0;
      dropped_q <= 1'b0;
    end else begin
      fill_q    <= fill_d;
      drain_q   <= drain_d;
      dropped_q <= dropped_d;
    end
  end

  // the row of cells; the head cell feeds the output
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic signed [DATA_W-1:0] prev_value, next_value;
    logic                     prev_gt, prev_occ;

    assign cell_occ[i] = (CNT_W'(i) < fill_q);

    if (i == 0) begin : g_head
      assign prev_value = value_i;
      assign prev_gt    = 1'b0;
      assign prev_occ   = 1'b1;
    end else begin : g_body
      assign prev_value = cell_value[i-1];
      assign prev_gt    = cell_gt[i-1];
      assign prev_occ   = cell_occ[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      // tail word beyond the count after a shift, so its content is moot
      assign next_value = cell_value[i];
    end else begin : g_mid
      assign next_value = cell_value[i+1];
    end

    isu_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .new_value_i  (value_i),
      .prev_value_i (prev_value),
      .next_value_i (next_value),
      .prev_gt_i    (prev_gt),
      .prev_occ_i   (prev_occ),
      .occ_i        (cell_occ[i]),
      .gt_o         (cell_gt[i]),
      .value_o      (cell_value[i])
    );
  end

  assign sorted_value_o = cell_value[0];
  assign last_out_o     = (fill_q == CNT_W'(1));
  assign overflow_o     = dropped_q;

  // a draining run always has at least one word left
  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_q |-> (fill_q != '0))
    else $error("drain with empty chain");

  // the fill count never passes the chain length
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(MAX_ITEMS))
    else $error("fill count beyond capacity");

  // a word flagged last starts the drain on the next cycle
  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_i) |=> out_valid_o)
    else $error("last word did not start a drain");

  // the run ends right after its final word is taken
  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_out_o) |=> (!out_valid_o && !overflow_o))
    else $error("output continued past the final word");

endmodule

`default_nettype wire
